>>> design/sfr_pkg.sv
// Shared types, register codes, reset values and the CRC step function
// for the stuffed frame receiver. No dependencies.
package sfr_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_COUNT_W = 5;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_BYTE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CRC_SEED       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CRC_POLY       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CRC_XOROUT     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_RELOAD = 3'd5;

  localparam logic [7:0]  RST_START_BYTE     = 8'h02;
  localparam logic [7:0]  RST_ESCAPE_BYTE    = 8'h1B;
  localparam logic [15:0] RST_CRC_SEED       = 16'hFFFF;
  localparam logic [15:0] RST_CRC_POLY       = 16'hA001;
  localparam logic [15:0] RST_CRC_XOROUT     = 16'h0000;
  localparam logic [7:0]  RST_TIMEOUT_RELOAD = 8'd25;

  localparam logic [7:0] MIN_FRAME_LEN = 8'd3;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  escape_byte;
    logic [15:0] crc_seed;
    logic [15:0] crc_poly;
    logic [15:0] crc_xorout;
    logic [7:0]  timeout_reload;
  } cfg_t;

  // One classified beat as it travels through the queue.
  typedef struct packed {
    logic       is_tick;
    logic       hit_escape;
    logic       hit_start;
    logic [7:0] data;
  } item_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_CMD,
    ST_READ,
    ST_DATA
  } back_state_t;

  // Reflected CRC, LSB first, one byte.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = b[k] ^ c[0];
      c  = c >> 1;
      if (fb) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

endpackage

>>> design/sfr_front.sv
// Front end: classifies incoming beats against the start and escape codes.
// Depends on sfr_pkg.
module sfr_front (
  input  logic          in_valid,
  input  logic          in_mode,
  input  logic [7:0]    in_rx_byte,
  input  sfr_pkg::cfg_t cfg,
  input  logic          q_full,
  output logic          in_stall,
  output logic          push,
  output sfr_pkg::item_t push_item
);
  import sfr_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.is_tick    = in_mode;
    push_item.data       = in_rx_byte;
    push_item.hit_escape = !in_mode && (in_rx_byte == cfg.escape_byte);
    push_item.hit_start  = !in_mode && (in_rx_byte == cfg.start_byte);
  end

endmodule

>>> design/sfr_queue.sv
// Short FIFO of classified beats between the front and back ends.
// Depends on sfr_pkg.
module sfr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sfr_pkg::item_t push_item,
  input  logic           pop,
  output logic           q_full,
  output logic           q_valid,
  output sfr_pkg::item_t q_item
);
  import sfr_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [NW-1:0] FULL_COUNT = NW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT  = PW'(QUEUE_DEPTH - 1);

  item_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;

  assign q_full  = (count_r == FULL_COUNT);
  assign q_valid = (count_r != '0);
  assign q_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/sfr_back.sv
// Back end: frame state machine, CRC check, payload buffer and packet emission.
// Depends on sfr_pkg.
module sfr_back #(
  parameter int BUFFER_DEPTH = sfr_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  sfr_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  sfr_pkg::item_t q_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_is_command,
  output logic [sfr_pkg::OUT_COUNT_W-1:0] out_payload_count,
  output logic           out_last
);
  import sfr_pkg::*;

  localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [7:0] POS_LIMIT = 8'(BUFFER_DEPTH + 2);

  back_state_t   state_r, state_nxt;

  logic          esc_r, esc_nxt;
  logic          in_frame_r, in_frame_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    pos_r, pos_nxt;
  logic [7:0]    tleft_r, tleft_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_cmd_r, out_cmd_nxt;
  logic [OUT_COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic          out_last_r, out_last_nxt;

  logic [7:0]    mem [BUFFER_DEPTH];
  logic [7:0]    rdata_r;
  logic          wr_en;
  logic [7:0]    wr_off;
  logic          rd_en;

  logic          emit_go;
  logic          out_free;
  logic          load;
  logic          cnt_zero;
  logic          idx_last;
  logic [15:0]   crc_x;
  logic [8:0]    pos_inc;
  logic [CW+OUT_COUNT_W-1:0] cnt_wide;

  assign pop      = q_valid && (state_r == ST_RUN);
  assign out_free = !out_valid_r || !out_stall;
  assign cnt_zero = (count_r == '0);
  assign idx_last = ((idx_r + 1'b1) == count_r);
  assign cnt_wide = {{OUT_COUNT_W{1'b0}}, count_r};
  assign wr_off   = pos_r - 8'd2;
  assign crc_x    = crc_r ^ cfg.crc_xorout;
  assign pos_inc  = {1'b0, pos_r} + 9'd1;
  assign rd_en    = (state_r == ST_READ);
  assign load     = out_free && ((state_r == ST_CMD) || (state_r == ST_DATA));

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_is_command    = out_cmd_r;
  assign out_payload_count = out_cnt_r;
  assign out_last          = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (emit_go) begin
          state_nxt = ST_CMD;
        end
      end
      ST_CMD: begin
        if (out_free) begin
          state_nxt = cnt_zero ? ST_RUN : ST_READ;
        end
      end
      ST_READ: state_nxt = ST_DATA;
      ST_DATA: begin
        if (out_free) begin
          state_nxt = idx_last ? ST_RUN : ST_READ;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // frame datapath and output register loads
  always_comb begin
    esc_nxt      = esc_r;
    in_frame_nxt = in_frame_r;
    crc_nxt      = crc_r;
    len_nxt      = len_r;
    pos_nxt      = pos_r;
    tleft_nxt    = tleft_r;
    cmd_nxt      = cmd_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    wr_en        = 1'b0;
    emit_go      = 1'b0;

    if (pop) begin
      if (q_item.is_tick) begin
        if (tleft_r != '0) begin
          tleft_nxt = tleft_r - 8'd1;
          if (tleft_r == 8'd1) begin
            in_frame_nxt = 1'b0;
            esc_nxt      = 1'b0;
          end
        end
      end else if (!esc_r && q_item.hit_escape) begin
        esc_nxt = 1'b1;
      end else if (!esc_r && q_item.hit_start) begin
        pos_nxt      = '0;
        tleft_nxt    = cfg.timeout_reload;
        in_frame_nxt = 1'b1;
        cmd_nxt      = '0;
        count_nxt    = '0;
        crc_nxt      = crc_feed(cfg.crc_seed, q_item.data, cfg.crc_poly);
      end else if (in_frame_r) begin
        tleft_nxt = cfg.timeout_reload;
        if (pos_r == '0) begin
          len_nxt = q_item.data;
          crc_nxt = crc_feed(crc_r, q_item.data, cfg.crc_poly);
          if (q_item.data < MIN_FRAME_LEN) begin
            in_frame_nxt = 1'b0;
          end
        end else if (pos_r > len_r) begin
          in_frame_nxt = 1'b0;
        end else if (pos_inc == {1'b0, len_r}) begin
          // check high byte after the final xor
          crc_nxt = crc_x;
          if (crc_x[15:8] != q_item.data) begin
            in_frame_nxt = 1'b0;
          end
        end else if (pos_r == len_r) begin
          in_frame_nxt = 1'b0;
          if (crc_r[7:0] == q_item.data) begin
            emit_go   = 1'b1;
            tleft_nxt = '0;
          end
        end else begin
          crc_nxt = crc_feed(crc_r, q_item.data, cfg.crc_poly);
          if (pos_r <= 8'd1) begin
            cmd_nxt = q_item.data;
          end else if (pos_r < POS_LIMIT) begin
            // keep payload while it fits; later bytes are only checked
            wr_en     = 1'b1;
            count_nxt = CW'(pos_r - 8'd1);
          end
        end
        pos_nxt = pos_r + 8'd1;
        esc_nxt = 1'b0;
      end else begin
        esc_nxt = 1'b0;
      end
    end

    if (state_r == ST_CMD) begin
      idx_nxt = '0;
    end else if (state_r == ST_DATA && out_free) begin
      idx_nxt = idx_r + 1'b1;
    end

    out_byte_nxt = out_byte_r;
    out_cmd_nxt  = out_cmd_r;
    out_cnt_nxt  = out_cnt_r;
    out_last_nxt = out_last_r;
    if (load) begin
      out_cnt_nxt = cnt_wide[OUT_COUNT_W-1:0];
      if (state_r == ST_CMD) begin
        out_byte_nxt = cmd_r;
        out_cmd_nxt  = 1'b1;
        out_last_nxt = cnt_zero;
      end else begin
        out_byte_nxt = rdata_r;
        out_cmd_nxt  = 1'b0;
        out_last_nxt = idx_last;
      end
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      esc_r       <= 1'b0;
      in_frame_r  <= 1'b0;
      crc_r       <= '0;
      len_r       <= '0;
      pos_r       <= '0;
      tleft_r     <= '0;
      cmd_r       <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      esc_r       <= esc_nxt;
      in_frame_r  <= in_frame_nxt;
      crc_r       <= crc_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      tleft_r     <= tleft_nxt;
      cmd_r       <= cmd_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  // payload buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_off[IW-1:0]] <= q_item.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[idx_r[IW-1:0]];
    end
  end

endmodule

>>> design/stuffed_frame_receiver_crc16.sv
// Top level of the byte-stuffed frame receiver with CRC-16 check.
// Holds the configuration registers; depends on sfr_pkg, sfr_front,
// sfr_queue and sfr_back.

// Each input beat is either a received byte (in_mode = 0) or a timeout tick
// (in_mode = 1). Beats are classified on entry and held in a two-entry queue;
// the back end retires one beat per cycle while no packet is being sent, so
// the block then sustains one beat a cycle; an accepted beat is held in the
// queue register before it updates the back-end state. When the CRC low byte
// of a good frame arrives, the back end sends the command byte and then each
// stored payload byte, each one fetched first by the registered read of the
// payload buffer; out_stall can hold any result. During a run no beats leave
// the queue; once it is full, in_stall rises. Results carry out_is_command on
// the first beat, out_last on the final one, and out_payload_count (stored
// bytes, saturating at BUFFER_DEPTH) on all of them. Frames with a bad length,
// a CRC mismatch or an expired timeout are dropped without any result. The
// payload buffer needs no clearing after reset: only entries written in the
// current frame are read. Write configuration only while the block is idle;
// writes to indexes beyond the timeout register are ignored.
module stuffed_frame_receiver_crc16 #(
  parameter int BUFFER_DEPTH = sfr_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic clk,
  input  logic rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_rx_byte,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_command,
  output logic [sfr_pkg::OUT_COUNT_W-1:0] out_payload_count,
  output logic       out_last,

  input  logic                           cfg_we,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sfr_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  q_full;
  logic  push;
  item_t push_item;
  logic  pop;
  logic  q_valid;
  item_t q_item;

  // Register writes: each register takes the low bits of the write data.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_START_BYTE:     cfg_nxt.start_byte     = cfg_wdata[7:0];
        CFG_ESCAPE_BYTE:    cfg_nxt.escape_byte    = cfg_wdata[7:0];
        CFG_CRC_SEED:       cfg_nxt.crc_seed       = cfg_wdata;
        CFG_CRC_POLY:       cfg_nxt.crc_poly       = cfg_wdata;
        CFG_CRC_XOROUT:     cfg_nxt.crc_xorout     = cfg_wdata;
        CFG_TIMEOUT_RELOAD: cfg_nxt.timeout_reload = cfg_wdata[7:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte     <= RST_START_BYTE;
      cfg_r.escape_byte    <= RST_ESCAPE_BYTE;
      cfg_r.crc_seed       <= RST_CRC_SEED;
      cfg_r.crc_poly       <= RST_CRC_POLY;
      cfg_r.crc_xorout     <= RST_CRC_XOROUT;
      cfg_r.timeout_reload <= RST_TIMEOUT_RELOAD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classify each beat and push it while the queue has room.
  sfr_front u_front (
    .in_valid   (in_valid),
    .in_mode    (in_mode),
    .in_rx_byte (in_rx_byte),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_item  (push_item)
  );

  sfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // Run the frame logic and send packets through the output register.
  sfr_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_is_command    (out_is_command),
    .out_payload_count (out_payload_count),
    .out_last          (out_last)
  );

endmodule
